FILE: hw/rtl/egc_pkg.sv
// ----------------------------------------------------------------------------
// egc_pkg: shared types and constants of the edge growth cost unit
// Field widths, register codes and the beat that travels through the
// square-root cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package egc_pkg;

    // Configuration register widths and reset values
    localparam int LINK_W   = 23;
    localparam int WEIGHT_W = 12;
    localparam int CFG_IDX_W = 1;
    localparam logic [LINK_W-1:0]   MAX_LINK_RST = 23'd26214;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST   = 12'd1024;

    // Datapath widths
    localparam int NORM_W = 16;                        // Q1.14 normal
    localparam int DOT_W  = 24;                        // link component used in the dot product
    localparam int SQR_W  = 2 * LINK_W;                // one squared component
    localparam int PRD_W  = DOT_W + NORM_W;            // one dot product term
    localparam int DSUM_W = PRD_W + 2;                 // sum of three terms
    localparam int SQ_W   = 48;                        // sum of squares, Q16.32
    localparam int ROOT_W = SQ_W / 2;                  // link length, Q8.16
    localparam int REM_W  = ROOT_W + 2;                // square-root remainder
    localparam int NORM_FRAC = 14;
    localparam int PROJ_W = DSUM_W - NORM_FRAC;        // |d.n| in Q12.16
    localparam int COST_W = 24;
    localparam int MULT_W = WEIGHT_W + ROOT_W;         // k * diff
    localparam int WFRAC  = 8;
    localparam int PEN_W  = MULT_W - WFRAC;            // penalty after scaling

    // Configuration register codes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_LINK     = 1'b0,
        CFG_ANGLE_WEIGHT = 1'b1
    } cfg_reg_t;

    // Beat moving down the square-root chain
    typedef struct packed {
        logic              far;    // some component already beyond the limit
        logic [SQ_W-1:0]   rad;    // radicand bits still to bring in, top first
        logic [REM_W-1:0]  rem;    // partial remainder
        logic [ROOT_W-1:0] root;   // partial root
        logic [PROJ_W-1:0] proj;   // projection on the normal, Q12.16
    } sq_beat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/edge_growth_cost_unit.sv
// ----------------------------------------------------------------------------
// edge_growth_cost_unit: growth cost of one graph edge
// Link length by pipelined square root, length limit and angle penalty.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one edge per beat: parent point,
//   child point and the child's unit normal. Output channel
//   (out_valid/out_ready) returns one beat per edge, in order: reachable and
//   edge_cost (zero when unreachable or for a zero-length link).
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   max_link_length (index 0) or angle_weight (index 1); cfg_ready is always
//   high. Write only while no edge is in flight.
//   Throughput: one edge per cycle while out_ready holds. The path from input
//   beat to output beat is the 24-cell square-root chain (one root bit per
//   cell) plus three front stages and two back stages.
//   Every stage holds one beat with its own valid; a stalled receiver fills
//   the chain from the output end, and in_ready drops only once the first
//   stage is occupied and cannot move.
//   Reset empties the pipeline and loads limit 26214 and weight 1024.
// ----------------------------------------------------------------------------
`default_nettype none

module edge_growth_cost_unit #(
    parameter int COORD_WIDTH = 24
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    // edge input
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire signed [COORD_WIDTH-1:0]        parent_x,
    input  wire signed [COORD_WIDTH-1:0]        parent_y,
    input  wire signed [COORD_WIDTH-1:0]        parent_z,
    input  wire signed [COORD_WIDTH-1:0]        child_x,
    input  wire signed [COORD_WIDTH-1:0]        child_y,
    input  wire signed [COORD_WIDTH-1:0]        child_z,
    input  wire signed [egc_pkg::NORM_W-1:0]    norm_x,
    input  wire signed [egc_pkg::NORM_W-1:0]    norm_y,
    input  wire signed [egc_pkg::NORM_W-1:0]    norm_z,
    // result
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic                                reachable,
    output logic [egc_pkg::COST_W-1:0]          edge_cost,
    // configuration
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire [egc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire [egc_pkg::LINK_W-1:0]           cfg_data
);

    // Configuration registers
    logic [egc_pkg::LINK_W-1:0]   max_link_reg;
    logic [egc_pkg::WEIGHT_W-1:0] angle_weight_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_link_reg     <= egc_pkg::MAX_LINK_RST;
            angle_weight_reg <= egc_pkg::WEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (egc_pkg::cfg_reg_t'(cfg_index))
                egc_pkg::CFG_MAX_LINK:     max_link_reg     <= cfg_data;
                egc_pkg::CFG_ANGLE_WEIGHT: angle_weight_reg <= cfg_data[egc_pkg::WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Chain links between front, root cells and back
    egc_pkg::sq_beat_t chain_beat  [egc_pkg::ROOT_W+1];
    logic              chain_valid [egc_pkg::ROOT_W+1];
    logic              chain_ready [egc_pkg::ROOT_W+1];

    egc_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .parent_x  (parent_x),
        .parent_y  (parent_y),
        .parent_z  (parent_z),
        .child_x   (child_x),
        .child_y   (child_y),
        .child_z   (child_z),
        .norm_x    (norm_x),
        .norm_y    (norm_y),
        .norm_z    (norm_z),
        .max_link  (max_link_reg),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_beat  (chain_beat[0])
    );

    // One cell per root bit, most significant first
    for (genvar g = 0; g < egc_pkg::ROOT_W; g++)
    begin : g_cell
        egc_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .in_beat   (chain_beat[g]),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1]),
            .out_beat  (chain_beat[g+1])
        );
    end

    egc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (chain_valid[egc_pkg::ROOT_W]),
        .in_ready     (chain_ready[egc_pkg::ROOT_W]),
        .in_beat      (chain_beat[egc_pkg::ROOT_W]),
        .max_link     (max_link_reg),
        .angle_weight (angle_weight_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .reachable    (reachable),
        .edge_cost    (edge_cost)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/egc_front.sv
// ----------------------------------------------------------------------------
// egc_front: link vector, squares and dot product
// Three registered stages: component differences and range check, per-axis
// multiplies, then sums and projection. Emits the first square-root beat.
// ----------------------------------------------------------------------------
`default_nettype none

module egc_front #(
    parameter int COORD_WIDTH = 24
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   in_valid,
    output logic                                  in_ready,
    input  wire signed [COORD_WIDTH-1:0]          parent_x,
    input  wire signed [COORD_WIDTH-1:0]          parent_y,
    input  wire signed [COORD_WIDTH-1:0]          parent_z,
    input  wire signed [COORD_WIDTH-1:0]          child_x,
    input  wire signed [COORD_WIDTH-1:0]          child_y,
    input  wire signed [COORD_WIDTH-1:0]          child_z,
    input  wire signed [egc_pkg::NORM_W-1:0]      norm_x,
    input  wire signed [egc_pkg::NORM_W-1:0]      norm_y,
    input  wire signed [egc_pkg::NORM_W-1:0]      norm_z,
    input  wire        [egc_pkg::LINK_W-1:0]      max_link,
    output logic                                  out_valid,
    input  wire                                   out_ready,
    output egc_pkg::sq_beat_t                     out_beat
);

    localparam int DXW = (COORD_WIDTH + 1 > egc_pkg::DOT_W) ? COORD_WIDTH + 1
                                                             : egc_pkg::DOT_W;

    // Stage handshake
    logic va_reg, vb_reg, vc_reg;
    logic ready_a, ready_b, ready_c;

    assign ready_c   = !vc_reg || out_ready;
    assign ready_b   = !vb_reg || ready_c;
    assign ready_a   = !va_reg || ready_b;
    assign in_ready  = ready_a;
    assign out_valid = vc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (ready_a) va_reg <= in_valid;
            if (ready_b) vb_reg <= va_reg;
            if (ready_c) vc_reg <= vb_reg;
        end
    end

    // Stage A: differences, magnitudes, per-component limit check
    logic signed [DXW-1:0]               d     [3];
    logic        [DXW-1:0]               mag   [3];
    logic signed [egc_pkg::NORM_W-1:0]   n_in  [3];
    logic                                far_next;

    logic signed [egc_pkg::DOT_W-1:0]    d_reg   [3];
    logic        [egc_pkg::LINK_W-1:0]   mag_reg [3];
    logic signed [egc_pkg::NORM_W-1:0]   n_reg   [3];
    logic                                far_a_reg;

    always_comb
    begin
        d[0] = DXW'(child_x) - DXW'(parent_x);
        d[1] = DXW'(child_y) - DXW'(parent_y);
        d[2] = DXW'(child_z) - DXW'(parent_z);
        n_in[0] = norm_x;
        n_in[1] = norm_y;
        n_in[2] = norm_z;
        far_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = d[i][DXW-1] ? DXW'(-d[i]) : DXW'(d[i]);
            if (mag[i] > DXW'(max_link))
                far_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_a && in_valid)
        begin
            for (int i = 0; i < 3; i++)
            begin
                // exact whenever the edge stays reachable
                d_reg[i]   <= d[i][egc_pkg::DOT_W-1:0];
                mag_reg[i] <= mag[i][egc_pkg::LINK_W-1:0];
                n_reg[i]   <= n_in[i];
            end
            far_a_reg <= far_next;
        end
    end

    // Stage B: squares and dot product terms
    logic        [egc_pkg::SQR_W-1:0]    sqr_reg [3];
    logic signed [egc_pkg::PRD_W-1:0]    prd_reg [3];
    logic                                far_b_reg;

    always_ff @(posedge clk)
    begin
        if (ready_b && va_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sqr_reg[i] <= egc_pkg::SQR_W'(mag_reg[i]) * egc_pkg::SQR_W'(mag_reg[i]);
                prd_reg[i] <= egc_pkg::PRD_W'(d_reg[i]) * egc_pkg::PRD_W'(n_reg[i]);
            end
            far_b_reg <= far_a_reg;
        end
    end

    // Stage C: sum of squares, projection on the normal
    logic        [egc_pkg::SQ_W-1:0]     sq_sum;
    logic signed [egc_pkg::DSUM_W-1:0]   dot;
    logic        [egc_pkg::DSUM_W-1:0]   dot_mag;
    egc_pkg::sq_beat_t                   beat_next;
    egc_pkg::sq_beat_t                   beat_reg;

    always_comb
    begin
        sq_sum = egc_pkg::SQ_W'(sqr_reg[0]) + egc_pkg::SQ_W'(sqr_reg[1])
               + egc_pkg::SQ_W'(sqr_reg[2]);
        dot = egc_pkg::DSUM_W'(prd_reg[0]) + egc_pkg::DSUM_W'(prd_reg[1])
            + egc_pkg::DSUM_W'(prd_reg[2]);
        dot_mag = dot[egc_pkg::DSUM_W-1] ? egc_pkg::DSUM_W'(-dot) : egc_pkg::DSUM_W'(dot);
        beat_next.far  = far_b_reg;
        beat_next.rad  = sq_sum;
        beat_next.rem  = '0;
        beat_next.root = '0;
        beat_next.proj = dot_mag[egc_pkg::DSUM_W-1:egc_pkg::NORM_FRAC];
    end

    always_ff @(posedge clk)
    begin
        if (ready_c && vb_reg)
            beat_reg <= beat_next;
    end

    assign out_beat = beat_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/egc_sqrt_cell.sv
// ----------------------------------------------------------------------------
// egc_sqrt_cell: one step of the digit-by-digit square root
// Brings in two radicand bits, settles one root bit and hands the beat to
// the next cell. Holds one beat with its own valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

module egc_sqrt_cell (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      in_valid,
    output logic                     in_ready,
    input  wire egc_pkg::sq_beat_t   in_beat,
    output logic                     out_valid,
    input  wire                      out_ready,
    output egc_pkg::sq_beat_t        out_beat
);

    logic                        valid_reg;
    egc_pkg::sq_beat_t           beat_reg;
    egc_pkg::sq_beat_t           beat_next;
    logic [egc_pkg::REM_W+1:0]   rem_try;
    logic [egc_pkg::REM_W+1:0]   trial;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

    // Trial subtract of (4*root + 1)
    always_comb
    begin
        rem_try = {in_beat.rem, in_beat.rad[egc_pkg::SQ_W-1 -: 2]};
        trial   = (egc_pkg::REM_W + 2)'({in_beat.root, 2'b01});
        beat_next      = in_beat;
        beat_next.rad  = {in_beat.rad[egc_pkg::SQ_W-3:0], 2'b00};
        if (rem_try >= trial)
        begin
            beat_next.rem  = egc_pkg::REM_W'(rem_try - trial);
            beat_next.root = {in_beat.root[egc_pkg::ROOT_W-2:0], 1'b1};
        end
        else
        begin
            beat_next.rem  = egc_pkg::REM_W'(rem_try);
            beat_next.root = {in_beat.root[egc_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            beat_reg <= beat_next;
    end

`ifndef SYNTHESIS
    // remainder never exceeds twice the partial root
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (egc_pkg::REM_W'(beat_reg.rem) <= {1'b0, beat_reg.root, 1'b0}))
        else $error("sqrt cell remainder out of bound");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/egc_back.sv
// ----------------------------------------------------------------------------
// egc_back: limit check, angle penalty and cost
// Two registered stages: length limit, clamped difference and weight
// multiply, then scaling, sum and saturation into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module egc_back (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             in_valid,
    output logic                            in_ready,
    input  wire egc_pkg::sq_beat_t          in_beat,
    input  wire [egc_pkg::LINK_W-1:0]       max_link,
    input  wire [egc_pkg::WEIGHT_W-1:0]     angle_weight,
    output logic                            out_valid,
    input  wire                             out_ready,
    output logic                            reachable,
    output logic [egc_pkg::COST_W-1:0]      edge_cost
);

    logic v1_reg, v2_reg;
    logic ready_1, ready_2;

    assign ready_2   = !v2_reg || out_ready;
    assign ready_1   = !v1_reg || ready_2;
    assign in_ready  = ready_1;
    assign out_valid = v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (ready_1) v1_reg <= in_valid;
            if (ready_2) v2_reg <= v1_reg;
        end
    end

    // Stage 1: limit check, clamped difference, weight multiply
    logic                            reach_next;
    logic [egc_pkg::PROJ_W-1:0]      root_ext;
    logic [egc_pkg::ROOT_W-1:0]      diff;
    logic                            reach1_reg;
    logic [egc_pkg::ROOT_W-1:0]      root1_reg;
    logic [egc_pkg::MULT_W-1:0]      prod1_reg;

    always_comb
    begin
        reach_next = !in_beat.far
                   && (in_beat.root <= egc_pkg::ROOT_W'(max_link));
        root_ext   = egc_pkg::PROJ_W'(in_beat.root);
        if (root_ext > in_beat.proj)
            diff = egc_pkg::ROOT_W'(root_ext - in_beat.proj);
        else
            diff = '0;
    end

    always_ff @(posedge clk)
    begin
        if (ready_1 && in_valid)
        begin
            reach1_reg <= reach_next;
            root1_reg  <= in_beat.root;
            prod1_reg  <= egc_pkg::MULT_W'(angle_weight) * egc_pkg::MULT_W'(diff);
        end
    end

    // Stage 2: cost = dist + penalty, saturated; zero when unreachable
    logic [egc_pkg::PEN_W:0]         cost_sum;
    logic [egc_pkg::COST_W-1:0]      cost_next;
    logic                            reach2_reg;
    logic [egc_pkg::COST_W-1:0]      cost2_reg;

    always_comb
    begin
        cost_sum = (egc_pkg::PEN_W + 1)'(root1_reg)
                 + (egc_pkg::PEN_W + 1)'(prod1_reg[egc_pkg::MULT_W-1:egc_pkg::WFRAC]);
        if (!reach1_reg)
            cost_next = '0;
        else if (|cost_sum[egc_pkg::PEN_W:egc_pkg::COST_W])
            cost_next = '1;
        else
            cost_next = cost_sum[egc_pkg::COST_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ready_2 && v1_reg)
        begin
            reach2_reg <= reach1_reg;
            cost2_reg  <= cost_next;
        end
    end

    assign reachable = reach2_reg;
    assign edge_cost = cost2_reg;

`ifndef SYNTHESIS
    // an unreachable edge always carries zero cost
    a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !reach2_reg) |-> (cost2_reg == '0))
        else $error("unreachable edge with nonzero cost");

    // a reachable edge never exceeds the limit
    a_reach_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && reach1_reg) |-> (root1_reg <= egc_pkg::ROOT_W'(max_link)))
        else $error("reachable edge longer than limit");

    // cost of a reachable edge is at least its length
    a_cost_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && reach1_reg) |-> (cost_next >= root1_reg))
        else $error("cost below link length");
`endif

endmodule

`default_nettype wire
